// File: rtl/core/cplm_pkg.sv
// cplm_pkg: shared types and constants of the complex power level meter
// controller states, datapath operation codes, command/status/config structs
// no dependencies
package cplm_pkg;

	localparam int LEVEL_W    = 40;
	localparam int DB_W       = 17;
	localparam int OUT_DATA_W = 64;
	localparam int STEP_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DB_MAX = 25600;
	localparam int DB_MIN = -51200;
	// round(10*log10(2) * 2^24)
	localparam int DB_K   = 50504453;

	localparam logic [15:0] ALPHA_RESET = 16'd26214;

	localparam logic [STEP_W-1:0] EMA_LAST  = 4'd3;
	localparam logic [STEP_W-1:0] NORM_LAST = 4'd5;
	localparam logic [STEP_W-1:0] LOG_LAST  = 4'd15;

	localparam logic [CFG_IDX_W-1:0] CFG_USE_AVG       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_Q16     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE_DB = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SQUARE,
		S_POWER,
		S_SEED,
		S_EMA,
		S_EMA_END,
		S_LEVEL,
		S_NORM_LOAD,
		S_NORM,
		S_MANT,
		S_LOG,
		S_SCALE,
		S_ROUND,
		S_CLAMP,
		S_FLOOR
	} cplm_state_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_LOAD,
		OP_READ,
		OP_SQUARE,
		OP_POWER,
		OP_SEED,
		OP_EMA,
		OP_EMA_END,
		OP_LEVEL,
		OP_NORM_LOAD,
		OP_NORM,
		OP_MANT,
		OP_LOG,
		OP_SCALE,
		OP_ROUND,
		OP_CLAMP,
		OP_FLOOR
	} cplm_op_t;

	typedef struct packed {
		cplm_op_t          op;
		logic [STEP_W-1:0] step;
	} cplm_cmd_t;

	typedef struct packed {
		logic level_zero;
	} cplm_stat_t;

	typedef struct packed {
		logic              use_avg;
		logic [15:0]       alpha_q16;
		logic signed [15:0] full_scale_db;
	} cplm_cfg_t;

endpackage

// File: rtl/core/complex_power_level_meter.sv
// complex_power_level_meter: top level, config registers and result register
// instantiates cplm_ctrl and cplm_datapath; depends on cplm_pkg
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tdata i,q; tuser cmd; tlast last_of_block
//  m_*     | out       | m_tvalid/m_tready  | tdata level, level_db
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a read item is done in the idle state; a sample goes through square and power, then
// seeds a block or goes through the ema (four passes of one 17x20 multiplier)
// a last sample then adds the level update, 6 normalize steps, 16 log squaring steps on one
// 32x32 multiplier and the db scale; only the level update and db floor when the level is zero
// reset clears level, db, running sum and block state; no clearing pass
// s_tready is low while an item is in work or a read result waits on m_tready
module complex_power_level_meter #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [SAMPLE_BITS-1:0] i_sample, [2*SAMPLE_BITS-1:SAMPLE_BITS] q_sample
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
	// cmd
	input  logic                                s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [39:0] level, [56:40] level_db
	output logic [cplm_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cplm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cplm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	cplm_pkg::cplm_cfg_t                    cfg_q;
	cplm_pkg::cplm_cmd_t                    cmd;
	cplm_pkg::cplm_stat_t                   stat;
	logic [cplm_pkg::LEVEL_W-1:0]           level;
	logic signed [cplm_pkg::DB_W-1:0]       level_db;
	logic [cplm_pkg::LEVEL_W-1:0]           out_level_q;
	logic [cplm_pkg::DB_W-1:0]              out_db_q;
	logic                                   out_valid_q;
	logic                                   out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_avg       <= 1'b0;
			cfg_q.alpha_q16     <= cplm_pkg::ALPHA_RESET;
			cfg_q.full_scale_db <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cplm_pkg::CFG_USE_AVG:       cfg_q.use_avg       <= cfg_data[0];
				cplm_pkg::CFG_ALPHA_Q16:     cfg_q.alpha_q16     <= cfg_data;
				cplm_pkg::CFG_FULL_SCALE_DB: cfg_q.full_scale_db <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == cplm_pkg::OP_READ) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register, loaded with the level and db as they stand before the clear
	always_ff @(posedge clk) begin
		if (cmd.op == cplm_pkg::OP_READ) begin
			out_level_q <= level;
			out_db_q    <= level_db;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = cplm_pkg::OUT_DATA_W'({out_db_q, out_level_q});

	cplm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_read  (s_tuser),
		.in_last  (s_tlast),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	cplm_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.FRAC_BITS   (FRAC_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.i_sample ($signed(s_tdata[SAMPLE_BITS-1:0])),
		.q_sample ($signed(s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
		.stat     (stat),
		.level    (level),
		.level_db (level_db)
	);

endmodule

// File: rtl/core/cplm_ctrl.sv
// cplm_ctrl: sequencer of the power level meter
// walks samples through square, power, seed/ema and, on a last sample, level and log/db steps
// depends on cplm_pkg
module cplm_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_read,
	input  logic                   in_last,
	input  logic                   out_free,
	input  cplm_pkg::cplm_stat_t   stat,
	output logic                   in_ready,
	output cplm_pkg::cplm_cmd_t    cmd
);

	cplm_pkg::cplm_state_t          state_q, state_d;
	logic [cplm_pkg::STEP_W-1:0]    cnt_q, cnt_d;
	logic                           in_block_q, in_block_d;
	logic                           last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= cplm_pkg::S_IDLE;
			cnt_q      <= '0;
			in_block_q <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			in_block_q <= in_block_d;
			last_q     <= last_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		in_block_d = in_block_q;
		last_d     = last_q;
		in_ready   = 1'b0;
		cmd.op     = cplm_pkg::OP_IDLE;
		cmd.step   = cnt_q;
		case (state_q)
			cplm_pkg::S_IDLE: begin
				in_ready = out_free;
				if (in_valid && out_free) begin
					if (in_read) begin
						cmd.op = cplm_pkg::OP_READ;
					end else begin
						cmd.op  = cplm_pkg::OP_LOAD;
						last_d  = in_last;
						state_d = cplm_pkg::S_SQUARE;
					end
				end
			end
			cplm_pkg::S_SQUARE: begin
				cmd.op  = cplm_pkg::OP_SQUARE;
				state_d = cplm_pkg::S_POWER;
			end
			cplm_pkg::S_POWER: begin
				cmd.op  = cplm_pkg::OP_POWER;
				cnt_d   = '0;
				state_d = in_block_q ? cplm_pkg::S_EMA : cplm_pkg::S_SEED;
			end
			cplm_pkg::S_SEED, cplm_pkg::S_EMA_END: begin
				cmd.op = (state_q == cplm_pkg::S_SEED) ? cplm_pkg::OP_SEED
					: cplm_pkg::OP_EMA_END;
				// end of block goes on to the level and db update
				if (last_q) begin
					in_block_d = 1'b0;
					state_d    = cplm_pkg::S_LEVEL;
				end else begin
					in_block_d = 1'b1;
					state_d    = cplm_pkg::S_IDLE;
				end
			end
			cplm_pkg::S_EMA: begin
				cmd.op = cplm_pkg::OP_EMA;
				if (cnt_q == cplm_pkg::EMA_LAST) begin
					state_d = cplm_pkg::S_EMA_END;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cplm_pkg::S_LEVEL: begin
				cmd.op  = cplm_pkg::OP_LEVEL;
				state_d = cplm_pkg::S_NORM_LOAD;
			end
			cplm_pkg::S_NORM_LOAD: begin
				cmd.op  = cplm_pkg::OP_NORM_LOAD;
				cnt_d   = '0;
				state_d = stat.level_zero ? cplm_pkg::S_FLOOR : cplm_pkg::S_NORM;
			end
			cplm_pkg::S_NORM: begin
				cmd.op = cplm_pkg::OP_NORM;
				if (cnt_q == cplm_pkg::NORM_LAST) begin
					state_d = cplm_pkg::S_MANT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cplm_pkg::S_MANT: begin
				cmd.op  = cplm_pkg::OP_MANT;
				cnt_d   = '0;
				state_d = cplm_pkg::S_LOG;
			end
			cplm_pkg::S_LOG: begin
				cmd.op = cplm_pkg::OP_LOG;
				if (cnt_q == cplm_pkg::LOG_LAST) begin
					state_d = cplm_pkg::S_SCALE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			cplm_pkg::S_SCALE: begin
				cmd.op  = cplm_pkg::OP_SCALE;
				state_d = cplm_pkg::S_ROUND;
			end
			cplm_pkg::S_ROUND: begin
				cmd.op  = cplm_pkg::OP_ROUND;
				state_d = cplm_pkg::S_CLAMP;
			end
			cplm_pkg::S_CLAMP: begin
				cmd.op  = cplm_pkg::OP_CLAMP;
				state_d = cplm_pkg::S_IDLE;
			end
			cplm_pkg::S_FLOOR: begin
				cmd.op  = cplm_pkg::OP_FLOOR;
				state_d = cplm_pkg::S_IDLE;
			end
			default: begin
				state_d = cplm_pkg::S_IDLE;
			end
		endcase
	end

	a_ema_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cplm_pkg::S_EMA) |-> (cnt_q <= cplm_pkg::EMA_LAST))
		else $error("ema step counter out of range");

	a_block_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cplm_pkg::S_LEVEL) |-> !in_block_q)
		else $error("level update while block still open");

	a_square_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cplm_pkg::S_SQUARE) |-> ($past(state_q) == cplm_pkg::S_IDLE))
		else $error("square step not preceded by an accepted item");

	a_norm_to_mant: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cplm_pkg::S_NORM && cnt_q == cplm_pkg::NORM_LAST)
		|=> (state_q == cplm_pkg::S_MANT))
		else $error("normalize pass did not end after its last step");

endmodule

// File: rtl/core/cplm_datapath.sv
// cplm_datapath: arithmetic of the power level meter
// power, shared ema multiplier, level update, log2 by squaring, db scaling
// depends on cplm_pkg
module cplm_datapath #(
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cplm_pkg::cplm_cmd_t            cmd,
	input  cplm_pkg::cplm_cfg_t            cfg,
	input  logic signed [SAMPLE_BITS-1:0]  i_sample,
	input  logic signed [SAMPLE_BITS-1:0]  q_sample,
	output cplm_pkg::cplm_stat_t           stat,
	output logic [cplm_pkg::LEVEL_W-1:0]   level,
	output logic signed [cplm_pkg::DB_W-1:0] level_db
);

	localparam int SQ_W     = 2 * SAMPLE_BITS;
	localparam int FRAC_OFS = FRAC_BITS * 65536;

	// payload registers
	logic signed [SAMPLE_BITS-1:0] i_q, q_q;
	logic [SQ_W-1:0]               sqi_q, sqq_q;
	logic [39:0]                   pwr_q;
	logic [55:0]                   acc_q;
	logic [39:0]                   xn_q;
	logic [5:0]                    sh_q;
	logic [31:0]                   m_q;
	logic [15:0]                   frac_q;
	logic signed [48:0]            prod_q;
	logic signed [18:0]            dbraw_q;

	// measurement state
	logic [39:0]                   sum_q;
	logic [39:0]                   level_q;
	logic signed [16:0]            db_q;

	// power
	logic [SQ_W-1:0]  sqi_d, sqq_d;
	logic [SQ_W:0]    pwr_raw;
	logic [63:0]      pwr_wide;
	logic [39:0]      pwr_sat;

	// ema multiplier, one 17x20 product per step
	logic [16:0]      mul_a;
	logic [39:0]      mul_src;
	logic [19:0]      mul_b;
	logic [36:0]      mul_p;
	logic [55:0]      acc_d;

	logic [40:0]      mean_sum;
	logic [39:0]      level_d;

	logic [5:0]       norm_amt;
	logic [39:0]      norm_mask;

	logic [63:0]      sqr;
	logic [32:0]      sqr_sh;

	logic [5:0]       exp_w;
	logic [22:0]      lrel_u;
	logic signed [22:0] lrel;
	logic signed [26:0] db_k;
	logic signed [48:0] rnd_sum;
	logic signed [16:0] rnd;

	assign sqi_d    = SQ_W'(i_q * i_q);
	assign sqq_d    = SQ_W'(q_q * q_q);
	assign pwr_raw  = (SQ_W+1)'(sqi_q) + (SQ_W+1)'(sqq_q);
	assign pwr_wide = 64'(pwr_raw) << FRAC_BITS;
	assign pwr_sat  = (pwr_wide[63:40] != '0) ? '1 : pwr_wide[39:0];

	// steps 0,1: alpha*pwr low/high half; steps 2,3: (1-alpha)*sum low/high half
	assign mul_a   = cmd.step[1] ? 17'(17'h10000 - {1'b0, cfg.alpha_q16})
		: {1'b0, cfg.alpha_q16};
	assign mul_src = cmd.step[1] ? sum_q : pwr_q;
	assign mul_b   = cmd.step[0] ? mul_src[39:20] : mul_src[19:0];
	assign mul_p   = {20'd0, mul_a} * {17'd0, mul_b};
	assign acc_d   = acc_q + (cmd.step[0] ? 56'({mul_p, 20'd0}) : 56'(mul_p));

	assign mean_sum = 41'(level_q) + 41'(sum_q) + 41'd1;
	assign level_d  = (cfg.use_avg && level_q != '0) ? mean_sum[40:1] : sum_q;

	// binary search normalize: 32, 16, 8, 4, 2, 1
	assign norm_amt  = 6'(6'd32 >> cmd.step[2:0]);
	assign norm_mask = ~(40'hFF_FFFF_FFFF >> norm_amt);

	assign sqr    = {32'd0, m_q} * {32'd0, m_q};
	assign sqr_sh = sqr[63:31];

	assign exp_w  = 6'd39 - sh_q;
	assign lrel_u = {1'b0, exp_w, frac_q} - 23'(FRAC_OFS);
	assign lrel   = $signed(lrel_u);
	assign db_k   = 27'(cplm_pkg::DB_K);

	// floor shift by 32 after adding one half
	assign rnd_sum = prod_q + (49'sd1 <<< 31);
	assign rnd     = $signed(rnd_sum[48:32]);

	always_ff @(posedge clk) begin
		case (cmd.op)
			cplm_pkg::OP_LOAD: begin
				i_q <= i_sample;
				q_q <= q_sample;
			end
			cplm_pkg::OP_SQUARE: begin
				sqi_q <= sqi_d;
				sqq_q <= sqq_d;
			end
			cplm_pkg::OP_POWER: begin
				pwr_q <= pwr_sat;
				acc_q <= 56'd32768;
			end
			cplm_pkg::OP_EMA: begin
				acc_q <= acc_d;
			end
			cplm_pkg::OP_NORM_LOAD: begin
				xn_q <= level_q;
				sh_q <= '0;
			end
			cplm_pkg::OP_NORM: begin
				if ((xn_q & norm_mask) == '0) begin
					xn_q <= xn_q << norm_amt;
					sh_q <= sh_q + norm_amt;
				end
			end
			cplm_pkg::OP_MANT: begin
				m_q    <= xn_q[39:8];
				frac_q <= '0;
			end
			cplm_pkg::OP_LOG: begin
				if (sqr_sh[32]) begin
					m_q              <= sqr_sh[32:1];
					frac_q[~cmd.step] <= 1'b1;
				end else begin
					m_q <= sqr_sh[31:0];
				end
			end
			cplm_pkg::OP_SCALE: begin
				prod_q <= lrel * db_k;
			end
			cplm_pkg::OP_ROUND: begin
				dbraw_q <= rnd - cfg.full_scale_db;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			level_q <= '0;
			db_q    <= '0;
		end else begin
			case (cmd.op)
				cplm_pkg::OP_READ: begin
					level_q <= '0;
					db_q    <= '0;
				end
				cplm_pkg::OP_SEED: begin
					sum_q <= pwr_q;
				end
				cplm_pkg::OP_EMA_END: begin
					sum_q <= acc_q[55:16];
				end
				cplm_pkg::OP_LEVEL: begin
					level_q <= level_d;
				end
				cplm_pkg::OP_CLAMP: begin
					if (dbraw_q > cplm_pkg::DB_MAX) begin
						db_q <= 17'(cplm_pkg::DB_MAX);
					end else if (dbraw_q < cplm_pkg::DB_MIN) begin
						db_q <= 17'(cplm_pkg::DB_MIN);
					end else begin
						db_q <= dbraw_q[16:0];
					end
				end
				cplm_pkg::OP_FLOOR: begin
					db_q <= 17'(cplm_pkg::DB_MIN);
				end
				default: begin
				end
			endcase
		end
	end

	assign stat.level_zero = (level_q == '0);
	assign level           = level_q;
	assign level_db        = db_q;

	a_db_range: assert property (@(posedge clk) disable iff (!arst_n)
		(db_q >= cplm_pkg::DB_MIN) && (db_q <= cplm_pkg::DB_MAX))
		else $error("stored db value outside its clamp range");

endmodule

// File: verif/tb_complex_power_level_meter.sv
// tb_complex_power_level_meter: self-checking bench for the i/q power level meter
// predicts level and db readings in-bench and checks them against the m_* stream
// depends on cplm_pkg and complex_power_level_meter
`timescale 1ns / 100ps

module tb_complex_power_level_meter;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 8;
	localparam int LEVEL_W     = cplm_pkg::LEVEL_W;
	localparam int DB_W        = cplm_pkg::DB_W;
	localparam int OUT_DATA_W  = cplm_pkg::OUT_DATA_W;
	localparam int CFG_IDX_W   = cplm_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = cplm_pkg::CFG_DATA_W;
	localparam logic [63:0] LEVEL_MAX = (64'd1 << LEVEL_W) - 64'd1;
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	// worst sample path is an ema sample that closes its block, allow margin
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic               cmd;
		logic signed [15:0] i_val;
		logic signed [15:0] q_val;
		logic               last;
	} iq_item_t;

	typedef struct {
		logic [LEVEL_W-1:0]     level;
		logic signed [DB_W-1:0] db;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// meter state as the bench expects it
	logic                   avg_on = 1'b0;
	logic [15:0]            alpha_w = cplm_pkg::ALPHA_RESET;
	logic signed [15:0]     fs_db = '0;
	logic [63:0]            run_sum = '0;
	logic                   blk_open = 1'b0;
	logic [LEVEL_W-1:0]     held_level = '0;
	logic signed [DB_W-1:0] held_db = '0;

	iq_item_t iq_q[$];
	reading_t reading_q[$];
	iq_item_t cur_item;
	reading_t want;
	bit in_flight = 1'b0;
	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	int send_gap = 0;
	int recv_stall = 0;
	int errors = 0;

	complex_power_level_meter #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic signed [DB_W-1:0] db_of_level(logic [LEVEL_W-1:0] x);
		int top;
		logic [63:0] mant;
		longint l16, prod, db;
		if (x == '0)
			return DB_W'(cplm_pkg::DB_MIN);
		top = 0;
		for (int k = 0; k < LEVEL_W; k++)
			if (x[k])
				top = k;
		// normalized mantissa in q1.31, then bitwise log2 by repeated squaring
		mant = ({24'b0, x} << (63 - top)) >> 32;
		l16 = longint'(top) << 16;
		for (int k = 0; k < 16; k++) begin
			mant = (mant * mant) >> 31;
			if (mant[32]) begin
				mant = mant >> 1;
				l16 = l16 | (longint'(1) << (15 - k));
			end
		end
		prod = (l16 - (longint'(FRAC_BITS) << 16)) * longint'(cplm_pkg::DB_K);
		db = ((prod + 64'sh8000_0000) >>> 32) - longint'(fs_db);
		if (db > cplm_pkg::DB_MAX)
			db = cplm_pkg::DB_MAX;
		if (db < cplm_pkg::DB_MIN)
			db = cplm_pkg::DB_MIN;
		return DB_W'(db);
	endfunction

	task automatic meter_accept(iq_item_t it);
		longint sq_sum;
		logic [63:0] pwr;
		reading_t rec;
		if (it.cmd == CMD_READ) begin
			rec.level = held_level;
			rec.db = held_db;
			reading_q.push_back(rec);
			held_level = '0;
			held_db = '0;
		end else begin
			sq_sum = longint'(it.i_val) * longint'(it.i_val)
				+ longint'(it.q_val) * longint'(it.q_val);
			pwr = 64'(sq_sum) << FRAC_BITS;
			if (pwr > LEVEL_MAX)
				pwr = LEVEL_MAX;
			if (!blk_open)
				run_sum = pwr;
			else
				run_sum = (64'(alpha_w) * pwr + (64'd65536 - 64'(alpha_w)) * run_sum
					+ 64'd32768) >> 16;
			if (it.last) begin
				if (avg_on && held_level != '0)
					held_level = LEVEL_W'((64'(held_level) + run_sum + 64'd1) >> 1);
				else
					held_level = run_sum[LEVEL_W-1:0];
				held_db = db_of_level(held_level);
				blk_open = 1'b0;
			end else begin
				blk_open = 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(string what, longint got, longint exp_val);
		$display("mismatch %s at %0t: got %0d, expected %0d", what, $realtime, got, exp_val);
		errors++;
	endtask

	// driver: one item on the s_* stream at a time, random gap after each item when send_idle is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				meter_accept(cur_item);
				in_flight = 1'b0;
				send_gap = send_idle ? $urandom_range(0, 11) : 0;
			end
			if (!in_flight) begin
				if (send_gap > 0)
					send_gap--;
				else if (iq_q.size() > 0) begin
					cur_item = iq_q.pop_front();
					in_flight = 1'b1;
				end
			end
			s_tvalid <= in_flight;
			s_tdata  <= {cur_item.q_val, cur_item.i_val};
			s_tuser  <= cur_item.cmd;
			s_tlast  <= cur_item.last;
		end
	end

	// monitor: check each reading, then stall m_tready for a random count when recv_idle is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (reading_q.size() == 0) begin
					report_mismatch("unexpected item", longint'(m_tdata[LEVEL_W-1:0]), 0);
				end else begin
					want = reading_q.pop_front();
					if (m_tdata[LEVEL_W-1:0] !== want.level)
						report_mismatch("level", longint'(m_tdata[LEVEL_W-1:0]),
							longint'(want.level));
					if (m_tdata[LEVEL_W+DB_W-1:LEVEL_W] !== want.db)
						report_mismatch("level_db",
							longint'($signed(m_tdata[LEVEL_W+DB_W-1:LEVEL_W])),
							longint'(want.db));
				end
				recv_stall = recv_idle ? $urandom_range(0, 11) : 0;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic signed [15:0] rand_component();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(0, 30)) - 16'sd15;
			3: return '0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic push_sample(logic signed [15:0] i_v, logic signed [15:0] q_v, logic last);
		iq_item_t it;
		it.cmd = CMD_SAMPLE;
		it.i_val = i_v;
		it.q_val = q_v;
		it.last = last;
		iq_q.push_back(it);
	endtask

	// read items carry junk in the sample fields
	task automatic push_read();
		iq_item_t it;
		it.cmd = CMD_READ;
		it.i_val = 16'($urandom);
		it.q_val = 16'($urandom);
		it.last = 1'($urandom_range(0, 1));
		iq_q.push_back(it);
	endtask

	task automatic gen_traffic(int n);
		int pushed, len;
		pushed = 0;
		while (pushed < n) begin
			case ($urandom_range(0, 9))
				8: begin
					push_read();
					pushed++;
				end
				9: begin
					push_sample(rand_component(), rand_component(), 1'($urandom_range(0, 1)));
					pushed++;
				end
				default: begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
						: $urandom_range(1, 6);
					for (int j = 0; j < len; j++)
						push_sample(rand_component(), rand_component(), j == len - 1);
					pushed += len;
					if ($urandom_range(0, 3) != 0) begin
						push_read();
						pushed++;
					end
				end
			endcase
		end
	endtask

	// no items left, no readings outstanding, then let the last block finish
	task automatic wait_quiet();
		while (iq_q.size() != 0 || in_flight || reading_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			cplm_pkg::CFG_USE_AVG:       avg_on = val[0];
			cplm_pkg::CFG_ALPHA_Q16:     alpha_w = val;
			cplm_pkg::CFG_FULL_SCALE_DB: fs_db = $signed(val);
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic avg_sel;
		logic [15:0] alpha_sel;
		logic [15:0] fs_sel;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset readout, extremes, zero floor, lone sample, read mid block
		push_read();
		push_sample(16'sh8000, 16'sh8000, 1'b1);
		push_read();
		push_sample('0, '0, 1'b1);
		push_read();
		push_read();
		push_sample(16'sh7fff, '0, 1'b0);
		push_sample('0, 16'sh8000, 1'b0);
		push_sample(16'sd1, 16'sd1, 1'b1);
		push_read();
		push_sample(16'sd1, '0, 1'b1);
		push_read();
		push_sample(16'sd100, -16'sd100, 1'b0);
		push_read();
		push_sample(-16'sd5, 16'sd7, 1'b1);
		push_read();
		push_sample(16'sh7fff, 16'sh7fff, 1'b0);
		push_read();
		push_sample(16'sh7fff, 16'sh8000, 1'b1);
		push_read();
		// db saturates high against a very low full-scale reference
		wait_quiet();
		cfg_write(cplm_pkg::CFG_FULL_SCALE_DB, 16'h8000);
		push_sample(16'sh8000, 16'sh8000, 1'b1);
		push_read();

		for (int ph = 0; ph < 8; ph++) begin
			wait_quiet();
			case (ph)
				0: begin
					avg_sel = 1'b0; alpha_sel = cplm_pkg::ALPHA_RESET; fs_sel = '0;
				end
				1: begin avg_sel = 1'b1; alpha_sel = 16'hffff; fs_sel = 16'h8000; end
				2: begin avg_sel = 1'b0; alpha_sel = 16'd1; fs_sel = 16'h7fff; end
				3: begin avg_sel = 1'b1; alpha_sel = '0; fs_sel = 16'(-25600); end
				4: begin avg_sel = 1'b1; alpha_sel = 16'($urandom); fs_sel = 16'd25600; end
				5: begin avg_sel = 1'b0; alpha_sel = 16'($urandom); fs_sel = 16'($urandom); end
				6: begin
					avg_sel = 1'b1; alpha_sel = cplm_pkg::ALPHA_RESET; fs_sel = '0;
				end
				default: begin
					avg_sel = 1'($urandom_range(0, 1));
					alpha_sel = 16'($urandom);
					fs_sel = 16'($urandom);
				end
			endcase
			cfg_write(cplm_pkg::CFG_USE_AVG, CFG_DATA_W'(avg_sel));
			cfg_write(cplm_pkg::CFG_ALPHA_Q16, alpha_sel);
			cfg_write(cplm_pkg::CFG_FULL_SCALE_DB, fs_sel);
			if (ph == 4)
				cfg_write(CFG_UNUSED, 16'($urandom));
			send_idle = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			recv_idle = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
			gen_traffic(250);
		end
		wait_quiet();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: complex_power_level_meter.f
rtl/core/cplm_pkg.sv
rtl/core/cplm_ctrl.sv
rtl/core/cplm_datapath.sv
rtl/core/complex_power_level_meter.sv
verif/tb_complex_power_level_meter.sv
